[rtl/evte_pkg.sv]
// Shared types and constants of the eased value tween engine.
package evte_pkg;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_MOVE = 2'd1,
      OP_SET  = 2'd2,
      OP_READ = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CURVE_LINEAR   = 2'd0,
      CURVE_EASE_IN  = 2'd1,
      CURVE_EASE_OUT = 2'd2,
      CURVE_ELASTIC  = 2'd3
   } curve_type;

   typedef enum logic [2:0] {
      MSEL_XX = 3'd0,
      MSEL_UU = 3'd1,
      MSEL_TX = 3'd2,
      MSEL_TU = 3'd3,
      MSEL_DF = 3'd4
   } msel_type;

   typedef enum logic [1:0] {
      FSEL_X           = 2'd0,
      FSEL_ROM         = 2'd1,
      FSEL_T           = 2'd2,
      FSEL_ONE_MINUS_T = 2'd3
   } fsel_type;

   typedef enum logic [1:0] {
      VSEL_END   = 2'd0,
      VSEL_START = 2'd1,
      VSEL_CALC  = 2'd2
   } vsel_type;

   typedef struct packed {
      op_type             operation;
      curve_type          curve;
      logic signed [31:0] target;
      logic [15:0]        span_ticks;
      logic [15:0]        hold_ticks;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               arrived;
      logic               redraw;
      logic               finished;
   } rsp_type;

   typedef struct packed {
      logic     load;
      logic     div_start;
      logic     div_step;
      logic     mul_start;
      msel_type msel;
      logic     mul_step;
      logic     f_load;
      fsel_type fsel;
      logic     val_load;
      vsel_type vsel;
      logic     out_load;
   } cmd_type;

   typedef struct packed {
      logic      at_span;
      logic      holding;
      curve_type curve;
      logic      cnt_zero;
      logic      rsp_free;
   } status_type;

endpackage

[rtl/evte_ctrl.sv]
// Controller state machine that sequences the divide, ROM and multiply steps.
module evte_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  evte_pkg::status_type status,
   output evte_pkg::cmd_type    cmd
);
   import evte_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_EVAL = 7'b0000010,
      S_DIV  = 7'b0000100,
      S_ROM  = 7'b0001000,
      S_MUL  = 7'b0010000,
      S_FACT = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_FINAL  = 2'd2
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_FIRST;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      cmd.msel = MSEL_XX;
      cmd.fsel = FSEL_X;
      cmd.vsel = VSEL_END;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            priority if (status.at_span) begin
               cmd.val_load = 1'b1;
               cmd.vsel     = VSEL_END;
               state_in     = S_OUT;
            end else if (status.holding) begin
               cmd.val_load = 1'b1;
               cmd.vsel     = VSEL_START;
               state_in     = S_OUT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (!status.cnt_zero) begin
               cmd.div_step = 1'b1;
            end else begin
               unique case (status.curve)
                  CURVE_LINEAR: begin
                     cmd.f_load = 1'b1;
                     cmd.fsel   = FSEL_X;
                     state_in   = S_FACT;
                  end
                  CURVE_ELASTIC: begin
                     state_in = S_ROM;
                  end
                  CURVE_EASE_IN: begin
                     cmd.mul_start = 1'b1;
                     cmd.msel      = MSEL_XX;
                     phase_in      = PH_FIRST;
                     state_in      = S_MUL;
                  end
                  CURVE_EASE_OUT: begin
                     cmd.mul_start = 1'b1;
                     cmd.msel      = MSEL_UU;
                     phase_in      = PH_FIRST;
                     state_in      = S_MUL;
                  end
               endcase
            end
         end
         S_ROM: begin
            cmd.f_load = 1'b1;
            cmd.fsel   = FSEL_ROM;
            state_in   = S_FACT;
         end
         S_FACT: begin
            cmd.mul_start = 1'b1;
            cmd.msel      = MSEL_DF;
            phase_in      = PH_FINAL;
            state_in      = S_MUL;
         end
         S_MUL: begin
            if (!status.cnt_zero) begin
               cmd.mul_step = 1'b1;
            end else begin
               unique case (phase_ff)
                  PH_FIRST: begin
                     cmd.mul_start = 1'b1;
                     cmd.msel      = (status.curve == CURVE_EASE_IN) ? MSEL_TX : MSEL_TU;
                     phase_in      = PH_SECOND;
                  end
                  PH_SECOND: begin
                     cmd.f_load = 1'b1;
                     cmd.fsel   = (status.curve == CURVE_EASE_IN) ? FSEL_T : FSEL_ONE_MINUS_T;
                     state_in   = S_FACT;
                  end
                  PH_FINAL: begin
                     cmd.val_load = 1'b1;
                     cmd.vsel     = VSEL_CALC;
                     state_in     = S_OUT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_OUT: begin
            if (status.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[rtl/evte_dp.sv]
// Datapath with the tween state, divider, shift-add multiplier, elastic ROM and result register.
module evte_dp #(
   parameter int ELASTIC_ROM_DEPTH = 1024,
   parameter int FRACTION_BITS     = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  evte_pkg::req_type    req_data,
   input  evte_pkg::cmd_type    cmd,
   output evte_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output evte_pkg::rsp_type    rsp_data
);
   import evte_pkg::*;

   localparam int FW  = FRACTION_BITS + 1;
   localparam int AW  = $clog2(ELASTIC_ROM_DEPTH);
   localparam int NW  = (FRACTION_BITS > AW) ? 16 + FRACTION_BITS : 16 + AW;
   localparam int MA  = 33;
   localparam int PW  = MA + FW;
   localparam int QW  = PW - FRACTION_BITS;
   localparam int RW  = QW + 2;
   localparam int CW  = $clog2(NW + 1);
   localparam logic [FW-1:0] ONE = FW'(1) << FRACTION_BITS;

   typedef logic [FW-1:0] rom_type [ELASTIC_ROM_DEPTH];

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;
   localparam logic [63:0] LN2_Q30 = 64'd744261118;

   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] rem;
      q   = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], n[b]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] sine_quarter(input logic [63:0] z);
      logic [63:0] z2;
      logic [63:0] acc;
      z2  = (z * z) >> 30;
      acc = 64'd5026995 - ((z2 * 64'd172272) >> 30);
      acc = 64'd85569306 - ((z2 * acc) >> 30);
      acc = 64'd693598668 - ((z2 * acc) >> 30);
      acc = 64'd1686629713 - ((z2 * acc) >> 30);
      return (z * acc) >> 30;
   endfunction

   function automatic logic [63:0] exp2_negative(input logic [63:0] y);
      logic [63:0] n;
      logic [63:0] g;
      logic [63:0] w;
      logic [63:0] sum;
      logic [63:0] term;
      n    = y >> 30;
      g    = Q30_ONE - (y & (Q30_ONE - 64'd1));
      w    = (g * LN2_Q30) >> 30;
      sum  = Q30_ONE;
      term = Q30_ONE;
      if (n > 64'd40) return 64'd0;
      for (int k = 1; k <= 10; k++) begin
         term = udiv64((term * w) >> 30, 64'(k));
         sum  = sum + term;
      end
      return sum >> (n + 64'd1);
   endfunction

   function automatic logic [FW-1:0] elastic_entry(input int i);
      logic [63:0] d;
      logic [63:0] num;
      logic [63:0] phase_wide;
      logic [31:0] phase;
      logic [63:0] y;
      logic [63:0] r;
      logic [63:0] z;
      logic [63:0] s;
      logic [63:0] m;
      logic [63:0] g;
      logic        neg;
      d          = 64'(ELASTIC_ROM_DEPTH);
      num        = 64'd40 * 64'(i) + 64'd9 * d;
      phase_wide = udiv64(num << 32, 64'd12 * d);
      phase      = phase_wide[31:0];
      y          = udiv64((64'd10 * 64'(i)) << 30, d);
      r          = {34'd0, phase[29:0]};
      z          = phase[30] ? (Q30_ONE - r) : r;
      neg        = phase[31];
      s          = sine_quarter(z);
      m          = (exp2_negative(y) * s) >> 30;
      if (neg) g = (m > Q30_ONE) ? 64'd0 : Q30_ONE - m;
      else     g = Q30_ONE + m;
      g = g >> (30 - FRACTION_BITS);
      return g[FW-1:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type t;
      for (int i = 0; i < ELASTIC_ROM_DEPTH; i++) begin
         t[i] = elastic_entry(i);
      end
      return t;
   endfunction

   localparam rom_type ROM_TABLE = build_rom();

   logic signed [31:0] start_ff, start_in;
   logic signed [31:0] end_ff, end_in;
   logic [15:0]        elapsed_ff, elapsed_in;
   logic [15:0]        span_ff, span_in;
   logic [15:0]        hold_ff, hold_in;
   curve_type          curve_ff, curve_in;
   logic               redraw_ff, redraw_in;
   logic               done_ff, done_in;
   logic               shown_ff, shown_in;
   logic               redraw_next;

   always_comb begin
      start_in    = start_ff;
      end_in      = end_ff;
      elapsed_in  = elapsed_ff;
      span_in     = span_ff;
      hold_in     = hold_ff;
      curve_in    = curve_ff;
      redraw_next = redraw_ff;
      done_in     = done_ff;
      unique case (req_data.operation)
         OP_TICK: begin
            priority if (hold_ff != 16'd0) begin
               hold_in = hold_ff - 16'd1;
            end else if (elapsed_ff == span_ff) begin
               if (!done_ff) begin
                  redraw_next = 1'b1;
                  done_in     = 1'b1;
               end
            end else begin
               elapsed_in  = elapsed_ff + 16'd1;
               redraw_next = 1'b1;
            end
         end
         OP_MOVE: begin
            curve_in    = req_data.curve;
            elapsed_in  = 16'd0;
            span_in     = req_data.span_ticks;
            hold_in     = req_data.hold_ticks;
            start_in    = end_ff;
            end_in      = req_data.target;
            redraw_next = 1'b1;
            done_in     = 1'b0;
         end
         OP_SET: begin
            elapsed_in  = 16'd0;
            span_in     = 16'd0;
            hold_in     = 16'd0;
            start_in    = req_data.target;
            end_in      = req_data.target;
            redraw_next = 1'b1;
            done_in     = 1'b1;
         end
         OP_READ: begin
         end
      endcase
      shown_in  = redraw_next;
      redraw_in = (req_data.operation == OP_READ) ? 1'b0 : redraw_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= '0;
         end_ff     <= '0;
         elapsed_ff <= '0;
         span_ff    <= '0;
         hold_ff    <= '0;
         curve_ff   <= CURVE_LINEAR;
         redraw_ff  <= 1'b1;
         done_ff    <= 1'b1;
         shown_ff   <= 1'b0;
      end else if (cmd.load) begin
         start_ff   <= start_in;
         end_ff     <= end_in;
         elapsed_ff <= elapsed_in;
         span_ff    <= span_in;
         hold_ff    <= hold_in;
         curve_ff   <= curve_in;
         redraw_ff  <= redraw_in;
         done_ff    <= done_in;
         shown_ff   <= shown_in;
      end
   end

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [15:0]   rem_ff, rem_in;
   logic [NW-1:0] num_ff, num_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [16:0]   rem_shift;
   logic          rem_ge;
   logic [PW-1:0] mul_a_ff, mul_a_in;
   logic [FW-1:0] mul_b_ff, mul_b_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [FW-1:0] x_now;
   logic [FW-1:0] u_now;
   logic [FW-1:0] t_now;
   logic [FW-1:0] f_ff, f_in;
   logic signed [32:0] diff;
   logic [MA-1:0] diff_mag;

   assign x_now     = quo_ff[FW-1:0];
   assign u_now     = ONE - x_now;
   assign t_now     = acc_ff[FRACTION_BITS +: FW];
   assign diff      = 33'(end_ff) - 33'(start_ff);
   assign diff_mag  = diff[32] ? MA'(-diff) : MA'(diff);
   assign rem_shift = {rem_ff, num_ff[NW-1]};
   assign rem_ge    = (rem_shift >= {1'b0, span_ff});

   always_comb begin
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      acc_in   = acc_ff;
      if (cmd.div_start) begin
         cnt_in = CW'(NW);
         rem_in = '0;
         quo_in = '0;
         if (curve_ff == CURVE_ELASTIC) begin
            num_in = NW'(NW'(elapsed_ff) * NW'(ELASTIC_ROM_DEPTH));
         end else begin
            num_in = NW'(elapsed_ff) << FRACTION_BITS;
         end
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff - CW'(1);
         rem_in = rem_ge ? 16'(rem_shift - {1'b0, span_ff}) : rem_shift[15:0];
         quo_in = {quo_ff[NW-2:0], rem_ge};
         num_in = num_ff << 1;
      end else if (cmd.mul_start) begin
         cnt_in = CW'(FW);
         acc_in = '0;
         unique case (cmd.msel)
            MSEL_XX: begin
               mul_a_in = PW'(x_now);
               mul_b_in = x_now;
            end
            MSEL_UU: begin
               mul_a_in = PW'(u_now);
               mul_b_in = u_now;
            end
            MSEL_TX: begin
               mul_a_in = PW'(t_now);
               mul_b_in = x_now;
            end
            MSEL_TU: begin
               mul_a_in = PW'(t_now);
               mul_b_in = u_now;
            end
            MSEL_DF: begin
               mul_a_in = PW'(diff_mag);
               mul_b_in = f_ff;
            end
            default: begin
               mul_a_in = '0;
               mul_b_in = '0;
            end
         endcase
      end else if (cmd.mul_step) begin
         cnt_in   = cnt_ff - CW'(1);
         acc_in   = mul_b_ff[0] ? acc_ff + mul_a_ff : acc_ff;
         mul_a_in = mul_a_ff << 1;
         mul_b_in = mul_b_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      quo_ff   <= quo_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      acc_ff   <= acc_in;
   end

   logic [AW-1:0] rom_addr;
   logic [FW-1:0] rom_q_ff;

   assign rom_addr = (quo_ff >= NW'(ELASTIC_ROM_DEPTH)) ? AW'(ELASTIC_ROM_DEPTH - 1)
                                                         : quo_ff[AW-1:0];

   always_ff @(posedge clock) begin
      rom_q_ff <= ROM_TABLE[rom_addr];
   end

   always_comb begin
      unique case (cmd.fsel)
         FSEL_X:           f_in = x_now;
         FSEL_ROM:         f_in = rom_q_ff;
         FSEL_T:           f_in = t_now;
         FSEL_ONE_MINUS_T: f_in = ONE - t_now;
         default:          f_in = x_now;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.f_load) begin
         f_ff <= f_in;
      end
   end

   logic [PW:0]          acc_round;
   logic [QW-1:0]        q_mag;
   logic signed [RW-1:0] sum_wide;
   logic signed [31:0]   calc_value;
   logic signed [31:0]   val_ff, val_in;

   assign acc_round = {1'b0, acc_ff} + ((PW + 1)'(1) << FRACTION_BITS) - (PW + 1)'(1);
   assign q_mag     = diff[32] ? acc_round[FRACTION_BITS +: QW] : acc_ff[FRACTION_BITS +: QW];
   assign sum_wide  = diff[32] ? RW'(start_ff) - $signed(RW'(q_mag))
                               : RW'(start_ff) + $signed(RW'(q_mag));

   always_comb begin
      priority if (sum_wide > RW'(32'sh7FFFFFFF)) begin
         calc_value = 32'sh7FFFFFFF;
      end else if (sum_wide < -RW'(33'sh080000000)) begin
         calc_value = -32'sh7FFFFFFF - 32'sd1;
      end else begin
         calc_value = sum_wide[31:0];
      end
   end

   always_comb begin
      unique case (cmd.vsel)
         VSEL_END:   val_in = end_ff;
         VSEL_START: val_in = start_ff;
         VSEL_CALC:  val_in = calc_value;
         default:    val_in = end_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.val_load) begin
         val_ff <= val_in;
      end
   end

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_ff.value    <= val_ff;
         rsp_ff.arrived  <= (elapsed_ff == span_ff);
         rsp_ff.redraw   <= shown_ff;
         rsp_ff.finished <= done_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;
   assign status.at_span  = (elapsed_ff == span_ff);
   assign status.holding  = (hold_ff != 16'd0);
   assign status.curve    = curve_ff;
   assign status.cnt_zero = (cnt_ff == '0);
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

endmodule

[rtl/eased_value_tween_engine.sv]
// Top level of the eased value tween engine: controller plus datapath.
// A result that is the end or start value skips the divider and multiplier; any other value is
// computed by the bit-serial divider and multiplier, with an elastic ROM read for the elastic
// curve and two extra multiplies for the cubic curves.
// One item is in flight; the next is taken the cycle after its result is loaded, even while
// that result waits. Synchronous active-high reset returns the tween to a settled zero value.
module eased_value_tween_engine #(
   parameter int ELASTIC_ROM_DEPTH = 1024,
   parameter int FRACTION_BITS     = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  evte_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output evte_pkg::rsp_type rsp_data
);
   import evte_pkg::*;

   cmd_type    cmd;
   status_type status;

   evte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   evte_dp #(
      .ELASTIC_ROM_DEPTH (ELASTIC_ROM_DEPTH),
      .FRACTION_BITS     (FRACTION_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/tb_eased_value_tween_engine.sv]
// Self-checking testbench of the eased value tween engine with a cycle-free value predictor.
`timescale 1ns / 100ps

module tb_eased_value_tween_engine;
   import evte_pkg::*;

   localparam int ROM_DEPTH = 1024;
   localparam int FRAC = 16;
   localparam longint unsigned Q30_ONE = 64'd1 << 30;
   localparam longint unsigned LN2_Q30 = 64'd744261118;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_q[$];
   int      fail_count = 0;
   bit      idle_on = 1'b1;
   int      items_sent = 0;

   logic [31:0] elastic_table [ROM_DEPTH];
   longint      tw_start, tw_end;
   int unsigned tw_elapsed, tw_span, tw_hold;
   curve_type   tw_curve;
   bit          tw_redraw, tw_done;

   eased_value_tween_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned sine_quarter(longint unsigned z);
      longint unsigned z2, acc;
      z2 = (z * z) >> 30;
      acc = 64'd5026995 - ((z2 * 64'd172272) >> 30);
      acc = 64'd85569306 - ((z2 * acc) >> 30);
      acc = 64'd693598668 - ((z2 * acc) >> 30);
      acc = 64'd1686629713 - ((z2 * acc) >> 30);
      return (z * acc) >> 30;
   endfunction

   function automatic longint unsigned exp2_neg(longint unsigned y);
      longint unsigned n, g, w, sum, term;
      n = y >> 30;
      if (n > 40) return 0;
      g = Q30_ONE - (y & (Q30_ONE - 1));
      w = (g * LN2_Q30) >> 30;
      sum = Q30_ONE;
      term = Q30_ONE;
      for (int k = 1; k <= 10; k++) begin
         term = ((term * w) >> 30) / k;
         sum += term;
      end
      return sum >> (n + 1);
   endfunction

   function automatic logic [31:0] elastic_sample(int i);
      longint unsigned d, num, y, r, z, s, m, g;
      logic [31:0] phase;
      bit neg;
      d = ROM_DEPTH;
      num = 40 * longint'(i) + 9 * d;
      phase = 32'((num << 32) / (12 * d));
      y = ((10 * longint'(i)) << 30) / d;
      r = phase[29:0];
      z = phase[30] ? (Q30_ONE - r) : r;
      neg = phase[31];
      s = sine_quarter(z);
      m = (exp2_neg(y) * s) >> 30;
      g = neg ? ((m > Q30_ONE) ? 0 : Q30_ONE - m) : Q30_ONE + m;
      return 32'(g >> (30 - FRAC));
   endfunction

   initial begin
      for (int i = 0; i < ROM_DEPTH; i++) elastic_table[i] = elastic_sample(i);
   end

   function automatic longint unsigned ease_factor();
      longint unsigned one, x, t;
      one = 64'd1 << FRAC;
      if (tw_span == 0) return one;
      x = (longint'(tw_elapsed) << FRAC) / tw_span;
      case (tw_curve)
         CURVE_LINEAR: return x;
         CURVE_EASE_IN: begin
            t = (x * x) >> FRAC;
            return (t * x) >> FRAC;
         end
         CURVE_EASE_OUT: begin
            t = (x > one) ? 0 : one - x;
            t = (((t * t) >> FRAC) * t) >> FRAC;
            return one - t;
         end
         default: begin
            t = (longint'(tw_elapsed) * ROM_DEPTH) / tw_span;
            if (t >= ROM_DEPTH) t = ROM_DEPTH - 1;
            return elastic_table[t];
         end
      endcase
   endfunction

   function automatic longint shown_value();
      longint prod, r;
      if (tw_elapsed == tw_span) return tw_end;
      if (tw_hold > 0) return tw_start;
      prod = (tw_end - tw_start) * longint'(ease_factor());
      r = tw_start + (prod >>> FRAC);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r;
   endfunction

   task automatic advance_tween(req_type it);
      rsp_type res;
      case (it.operation)
         OP_TICK: begin
            if (tw_hold > 0) tw_hold--;
            else if (tw_elapsed == tw_span) begin
               if (!tw_done) begin
                  tw_redraw = 1;
                  tw_done = 1;
               end
            end else begin
               tw_elapsed = (tw_elapsed + 1) & 16'hFFFF;
               tw_redraw = 1;
            end
         end
         OP_MOVE: begin
            tw_curve = it.curve;
            tw_elapsed = 0;
            tw_span = it.span_ticks;
            tw_hold = it.hold_ticks;
            tw_start = tw_end;
            tw_end = it.target;
            tw_redraw = 1;
            tw_done = 0;
         end
         OP_SET: begin
            tw_elapsed = 0;
            tw_span = 0;
            tw_hold = 0;
            tw_start = it.target;
            tw_end = it.target;
            tw_redraw = 1;
            tw_done = 1;
         end
         default: ;
      endcase
      res.redraw = tw_redraw;
      if (it.operation == OP_READ) tw_redraw = 0;
      res.value = 32'(shown_value());
      res.arrived = (tw_elapsed == tw_span);
      res.finished = tw_done;
      expected_q.push_back(res);
   endtask

   task automatic send_item(req_type it);
      if (idle_on) begin
         while ($urandom_range(99) < 28) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      advance_tween(it);
      items_sent++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("result with no expectation: value %h", rsp_data.value);
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_data.value !== want.value) begin
               $error("value expected %h actual %h", want.value, rsp_data.value);
               fail_count++;
            end
            if (rsp_data.arrived !== want.arrived) begin
               $error("arrived expected %b actual %b", want.arrived, rsp_data.arrived);
               fail_count++;
            end
            if (rsp_data.redraw !== want.redraw) begin
               $error("redraw expected %b actual %b", want.redraw, rsp_data.redraw);
               fail_count++;
            end
            if (rsp_data.finished !== want.finished) begin
               $error("finished expected %b actual %b", want.finished, rsp_data.finished);
               fail_count++;
            end
         end
      end
      rsp_stall <= (!reset && idle_on) ? ($urandom_range(99) < 28) : 1'b0;
   end

   function automatic req_type make_item(op_type op, curve_type cv, logic [31:0] tgt,
                                         logic [15:0] spn, logic [15:0] hld);
      req_type it;
      it.operation = op;
      it.curve = cv;
      it.target = tgt;
      it.span_ticks = spn;
      it.hold_ticks = hld;
      return it;
   endfunction

   function automatic req_type noise_fields(op_type op);
      return make_item(op, curve_type'($urandom_range(3)), $urandom, 16'($urandom),
                       16'($urandom));
   endfunction

   task automatic test_set_extremes();
      send_item(noise_fields(OP_READ));
      send_item(make_item(OP_SET, CURVE_ELASTIC, 32'h7FFFFFFF, 16'hFFFF, 16'hFFFF));
      send_item(noise_fields(OP_READ));
      send_item(make_item(OP_SET, CURVE_LINEAR, 32'h80000000, 16'h0000, 16'h0000));
      send_item(make_item(OP_SET, CURVE_LINEAR, 32'h00000000, 16'h0000, 16'h0000));
   endtask

   task automatic test_each_curve();
      for (int c = 0; c < 4; c++) begin
         send_item(make_item(OP_MOVE, curve_type'(c), 32'h00030000 * (c + 1), 16'd2, 16'd0));
         send_item(noise_fields(OP_TICK));
         send_item(noise_fields(OP_TICK));
      end
   endtask

   task automatic test_hold_and_zero_span();
      send_item(make_item(OP_MOVE, CURVE_LINEAR, 32'hFFFF0000, 16'd0, 16'd1));
      send_item(noise_fields(OP_TICK));
      send_item(noise_fields(OP_TICK));
      send_item(make_item(OP_MOVE, CURVE_EASE_OUT, 32'h00100000, 16'd3, 16'd2));
      send_item(noise_fields(OP_TICK));
   endtask

   task automatic test_elastic_overshoot();
      send_item(make_item(OP_SET, CURVE_LINEAR, 32'h80000000, 16'd0, 16'd0));
      send_item(make_item(OP_MOVE, CURVE_ELASTIC, 32'h7FFFFFFF, 16'd5, 16'd0));
      send_item(noise_fields(OP_TICK));
      send_item(noise_fields(OP_TICK));
   endtask

   function automatic logic [31:0] pick_target();
      case ($urandom_range(5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_random_tweens();
      int kind, nticks;
      logic [15:0] spn, hld;
      while (items_sent < 730) begin
         idle_on = !(items_sent >= 350 && items_sent < 500);
         kind = $urandom_range(99);
         if (kind < 65) begin
            spn = ($urandom_range(99) < 88) ? 16'($urandom_range(30)) : 16'($urandom);
            hld = ($urandom_range(99) < 90) ? 16'($urandom_range(4)) : 16'($urandom);
            send_item(make_item(OP_MOVE, curve_type'($urandom_range(3)), pick_target(),
                                spn, hld));
            nticks = spn + ((hld > 6) ? 6 : hld) + $urandom_range(2);
            if (nticks > 40) nticks = 40;
            if ($urandom_range(9) == 0) nticks = $urandom_range(nticks);
            for (int t = 0; t < nticks; t++) begin
               send_item(noise_fields(($urandom_range(9) == 0) ? OP_READ : OP_TICK));
            end
         end else if (kind < 80) begin
            send_item(make_item(OP_SET, curve_type'($urandom_range(3)), pick_target(),
                                16'($urandom), 16'($urandom)));
         end else begin
            send_item(noise_fields(op_type'($urandom_range(3))));
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      tw_start = 0;
      tw_end = 0;
      tw_elapsed = 0;
      tw_span = 0;
      tw_hold = 0;
      tw_curve = CURVE_LINEAR;
      tw_redraw = 1;
      tw_done = 1;
      test_set_extremes();
      test_each_curve();
      test_hold_and_zero_span();
      test_elastic_overshoot();
      test_random_tweens();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (fail_count == 0 && expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
